// File: hdl/udfa_pkg.sv
// ----------------------------------------------------------------------------
// udfa_pkg
// Shared types, constants and lookup functions for the UTF-8 DFA decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package udfa_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ClassW   = 4;
  localparam int unsigned StateW   = 4;
  localparam int unsigned CpW      = 21;
  localparam int unsigned NumState = 9;
  localparam int unsigned NumClass = 12;
  localparam int unsigned ContW    = 6;

  localparam logic [StateW-1:0] StAccept = 4'd0;
  localparam logic [StateW-1:0] StReject = 4'd1;

  localparam logic [ByteW-1:0] LeadMask = 8'hFF;

  typedef logic [StateW-1:0] state_t;
  typedef logic [ClassW-1:0] class_t;
  typedef logic [CpW-1:0]    cp_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    class_t           cls;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t head;
  } head_t;

  localparam state_t TRANS [NumState][NumClass] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  function automatic class_t byte_class(input logic [ByteW-1:0] b);
    class_t c;
    if (b < 8'h80)       c = 4'd0;
    else if (b < 8'h90)  c = 4'd1;
    else if (b < 8'hA0)  c = 4'd9;
    else if (b < 8'hC0)  c = 4'd7;
    else if (b < 8'hC2)  c = 4'd8;
    else if (b < 8'hE0)  c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0)  c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4)  c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else                 c = 4'd8;
    return c;
  endfunction

  function automatic state_t next_state(input state_t st, input class_t cls);
    state_t s;
    s = StReject;
    if (st < state_t'(NumState) && cls < class_t'(NumClass)) begin
      s = TRANS[st][cls];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/udfa_if.sv
// ----------------------------------------------------------------------------
// udfa_if
// Valid/ready channel interfaces for input bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface udfa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface udfa_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        complete;
  logic        rejected;

  modport source (output valid, output code_point, output complete, output rejected,
                  input ready);
  modport sink   (input valid, input code_point, input complete, input rejected,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/utf8_dfa_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_dfa_decoder_core
// Validating UTF-8 decoder: one result per input byte.
// ----------------------------------------------------------------------------
// Sustains one byte per cycle while the result side takes results. Each byte
// passes through the queue, then the result register: the front classifies
// each byte into a two-entry queue, and the back applies the state/code point
// update and loads the result register. The rate is set by the state loop;
// while the result side holds off, the queue takes two more bytes before the
// input stalls. Each result carries the code point when complete is high
// (zero otherwise) and a sticky reject flag that holds until reset.
`default_nettype none

module utf8_dfa_decoder_core
  import udfa_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  udfa_in_if.sink    byte_i,
  udfa_out_if.source cp_o
);

  head_t      head;
  logic       pop;
  logic [1:0] q_count;
  state_t     dfa_state;

  udfa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_i.valid),
    .byte_i  (byte_i.in_byte),
    .ready_o (byte_i.ready),
    .head_o  (head),
    .pop_i   (pop),
    .count_o (q_count)
  );

  udfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .valid_o      (cp_o.valid),
    .ready_i      (cp_o.ready),
    .code_point_o (cp_o.code_point),
    .complete_o   (cp_o.complete),
    .rejected_o   (cp_o.rejected),
    .state_o      (dfa_state)
  );

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dfa_state < state_t'(NumState))
    else $error("dfa state out of range");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count != 2'd3)
    else $error("queue count overflow");

  a_result_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_o.valid |-> !(cp_o.complete && cp_o.rejected))
    else $error("complete and rejected both set");

  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cp_o.valid && !cp_o.complete) |-> (cp_o.code_point == '0))
    else $error("code point nonzero on incomplete result");

  a_reject_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dfa_state == StReject) |=> (dfa_state == StReject))
    else $error("left reject state");

endmodule

`default_nettype wire

// File: hdl/udfa_front.sv
// ----------------------------------------------------------------------------
// udfa_front
// Accepts input bytes, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module udfa_front
  import udfa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [ByteW-1:0]  byte_i,
  output logic                   ready_o,
  output head_t                  head_o,
  input  wire logic              pop_i,
  output logic [1:0]             count_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign ready_o = (count_q != 2'd2);
  assign push    = valid_i && ready_o;
  assign pop     = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{data: byte_i, cls: byte_class(byte_i)};
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.head  = mem_q[rd_ptr_q];
  assign count_o      = count_q;

endmodule

`default_nettype wire

// File: hdl/udfa_back.sv
// ----------------------------------------------------------------------------
// udfa_back
// Runs the DFA and partial code point update, drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module udfa_back
  import udfa_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  head_t       head_i,
  output logic        pop_o,
  output logic        valid_o,
  input  wire logic   ready_i,
  output cp_t         code_point_o,
  output logic        complete_o,
  output logic        rejected_o,
  output state_t      state_o
);

  state_t state_q, state_d;
  cp_t    part_q, part_d;
  logic   out_vld_q;
  cp_t    cp_q, cp_d;
  logic   cmpl_q, rej_q;
  logic   adv;

  assign adv   = head_i.valid && (!out_vld_q || ready_i);
  assign pop_o = adv;

  always_comb begin
    if (state_q == StAccept) begin
      part_d = cp_t'((LeadMask >> head_i.head.cls) & head_i.head.data);
    end else begin
      part_d = {part_q[CpW-ContW-1:0], head_i.head.data[ContW-1:0]};
    end
    state_d = next_state(state_q, head_i.head.cls);
    cp_d    = (state_d == StAccept) ? part_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StAccept;
      part_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        state_q <= state_d;
        part_q  <= part_d;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cp_q   <= cp_d;
      cmpl_q <= (state_d == StAccept);
      rej_q  <= (state_d == StReject);
    end
  end

  assign valid_o      = out_vld_q;
  assign code_point_o = cp_q;
  assign complete_o   = cmpl_q;
  assign rejected_o   = rej_q;
  assign state_o      = state_q;

endmodule

`default_nettype wire

// File: verif/udfa_checker.sv
// ----------------------------------------------------------------------------
// udfa_checker
// Watches the byte and code point channels of the UTF-8 DFA decoder. Every
// accepted byte advances a local copy of the decoder state and queues the
// result it should produce. Every accepted result is compared field by field
// against the oldest queued one. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module udfa_checker
  import udfa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  udfa_in_if        byte_mon,
  udfa_out_if       cp_mon,
  output int        mismatches_o,
  output int        pending_o
);

  typedef enum logic [3:0] {
    CL_ASCII    = 4'd0,   // 00..7F
    CL_CONT_LO  = 4'd1,   // 80..8F
    CL_LEAD2    = 4'd2,   // C2..DF
    CL_LEAD3    = 4'd3,   // E1..EC, EE..EF
    CL_LEAD_ED  = 4'd4,
    CL_LEAD_F4  = 4'd5,
    CL_LEAD4    = 4'd6,   // F1..F3
    CL_CONT_HI  = 4'd7,   // A0..BF
    CL_INVALID  = 4'd8,   // C0, C1, F5..FF
    CL_CONT_MID = 4'd9,   // 90..9F
    CL_LEAD_E0  = 4'd10,
    CL_LEAD_F0  = 4'd11
  } byte_cls_e;

  typedef enum logic [3:0] {
    ST_ACCEPT = 4'd0,
    ST_REJECT = 4'd1,
    ST_NEED1  = 4'd2,
    ST_NEED2  = 4'd3,
    ST_E0     = 4'd4,
    ST_ED     = 4'd5,
    ST_F0     = 4'd6,
    ST_NEED3  = 4'd7,
    ST_F4     = 4'd8
  } dec_state_e;

  typedef struct packed {
    cp_t  code_point;
    logic complete;
    logic rejected;
  } dec_result_t;

  dec_state_e  dec_state;
  cp_t         partial_cp;
  dec_result_t pending_results [$];

  function automatic byte_cls_e classify(input logic [7:0] b);
    byte_cls_e c;
    if (b >= 8'hF5)      c = CL_INVALID;
    else if (b == 8'hF4) c = CL_LEAD_F4;
    else if (b >= 8'hF1) c = CL_LEAD4;
    else if (b == 8'hF0) c = CL_LEAD_F0;
    else if (b == 8'hED) c = CL_LEAD_ED;
    else if (b == 8'hE0) c = CL_LEAD_E0;
    else if (b >= 8'hE1) c = CL_LEAD3;
    else if (b >= 8'hC2) c = CL_LEAD2;
    else if (b >= 8'hC0) c = CL_INVALID;
    else if (b >= 8'hA0) c = CL_CONT_HI;
    else if (b >= 8'h90) c = CL_CONT_MID;
    else if (b >= 8'h80) c = CL_CONT_LO;
    else                 c = CL_ASCII;
    return c;
  endfunction

  function automatic dec_state_e next_dec_state(input dec_state_e st, input byte_cls_e c);
    logic       lo, mid, hi;
    dec_state_e nx;
    lo  = (c == CL_CONT_LO);
    mid = (c == CL_CONT_MID);
    hi  = (c == CL_CONT_HI);
    nx  = ST_REJECT;
    case (st)
      ST_ACCEPT: begin
        case (c)
          CL_ASCII:   nx = ST_ACCEPT;
          CL_LEAD2:   nx = ST_NEED1;
          CL_LEAD3:   nx = ST_NEED2;
          CL_LEAD4:   nx = ST_NEED3;
          CL_LEAD_E0: nx = ST_E0;
          CL_LEAD_ED: nx = ST_ED;
          CL_LEAD_F0: nx = ST_F0;
          CL_LEAD_F4: nx = ST_F4;
          default:    nx = ST_REJECT;
        endcase
      end
      ST_NEED1: if (lo || mid || hi) nx = ST_ACCEPT;
      ST_NEED2: if (lo || mid || hi) nx = ST_NEED1;
      ST_NEED3: if (lo || mid || hi) nx = ST_NEED2;
      ST_E0:    if (hi) nx = ST_NEED1;          // overlong below 0x800
      ST_ED:    if (lo || mid) nx = ST_NEED1;   // surrogates
      ST_F0:    if (mid || hi) nx = ST_NEED2;   // overlong below 0x10000
      ST_F4:    if (lo) nx = ST_NEED2;          // above 0x10FFFF
      default:  nx = ST_REJECT;
    endcase
    return nx;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_proc
    byte_cls_e   cls;
    dec_state_e  nxt;
    dec_result_t want;
    dec_result_t got;
    if (!rst_ni) begin
      dec_state  = ST_ACCEPT;
      partial_cp = '0;
      pending_results.delete();
      mismatches_o = 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready) begin
        cls = classify(byte_mon.in_byte);
        if (dec_state == ST_ACCEPT) begin
          partial_cp = cp_t'(byte_mon.in_byte & (8'hFF >> cls));
        end else begin
          partial_cp = {partial_cp[CpW-ContW-1:0], byte_mon.in_byte[ContW-1:0]};
        end
        nxt       = next_dec_state(dec_state, cls);
        dec_state = nxt;
        want.complete   = (nxt == ST_ACCEPT);
        want.rejected   = (nxt == ST_REJECT);
        want.code_point = want.complete ? partial_cp : '0;
        pending_results.push_back(want);
      end
      if (cp_mon.valid && cp_mon.ready) begin
        got.code_point = cp_mon.code_point;
        got.complete   = cp_mon.complete;
        got.rejected   = cp_mon.rejected;
        if (pending_results.size() == 0) begin
          $display("%0t udfa: unexpected transaction cp=0x%06h complete=%b rejected=%b",
                   $time, got.code_point, got.complete, got.rejected);
          mismatches_o++;
        end else begin
          want = pending_results.pop_front();
          if (got.code_point !== want.code_point) begin
            $display("%0t udfa: code_point expected 0x%06h actual 0x%06h",
                     $time, want.code_point, got.code_point);
            mismatches_o++;
          end
          if (got.complete !== want.complete) begin
            $display("%0t udfa: complete expected %b actual %b",
                     $time, want.complete, got.complete);
            mismatches_o++;
          end
          if (got.rejected !== want.rejected) begin
            $display("%0t udfa: rejected expected %b actual %b",
                     $time, want.rejected, got.rejected);
            mismatches_o++;
          end
        end
      end
    end
    pending_o = pending_results.size();
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for utf8_dfa_decoder_core. Feeds boundary code points, then a
// long stream of randomly encoded valid scalars, then one malformed sequence
// of a randomly chosen kind followed by random bytes (reject is sticky, so
// this comes last). Both channels idle at random, and the result side holds
// off once for a long stretch to back up the input. udfa_checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top
  import udfa_pkg::*;
();

  typedef enum int {
    BRK_STRAY_CONT,
    BRK_BAD_BYTE,
    BRK_OVERLONG,
    BRK_SURROGATE,
    BRK_ABOVE_MAX,
    BRK_TRUNCATED
  } break_e;

  localparam int RandomBytes = 1130;
  localparam int NoiseBytes  = 100;
  localparam int HoldAfter   = 300;
  localparam int HoldCycles  = 80;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   pending;
  int   rx_count;
  logic long_hold;

  logic [7:0] utf8_bytes [$];

  udfa_in_if  byte_if ();
  udfa_out_if cp_if ();

  utf8_dfa_decoder_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .cp_o   (cp_if)
  );

  udfa_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_mon     (byte_if),
    .cp_mon       (cp_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    #500000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic push_scalar(input cp_t v);
    if (v < 21'h80) begin
      utf8_bytes.push_back(v[7:0]);
    end else if (v < 21'h800) begin
      utf8_bytes.push_back({3'b110, v[10:6]});
      utf8_bytes.push_back({2'b10, v[5:0]});
    end else if (v < 21'h10000) begin
      utf8_bytes.push_back({4'b1110, v[15:12]});
      utf8_bytes.push_back({2'b10, v[11:6]});
      utf8_bytes.push_back({2'b10, v[5:0]});
    end else begin
      utf8_bytes.push_back({5'b11110, v[20:18]});
      utf8_bytes.push_back({2'b10, v[17:12]});
      utf8_bytes.push_back({2'b10, v[11:6]});
      utf8_bytes.push_back({2'b10, v[5:0]});
    end
  endtask

  function automatic cp_t random_scalar();
    cp_t         lo_v;
    cp_t         hi_v;
    cp_t         v;
    int unsigned pick;
    case ($urandom_range(1, 4))
      1:       begin lo_v = 21'h0;     hi_v = 21'h7F;     end
      2:       begin lo_v = 21'h80;    hi_v = 21'h7FF;    end
      3:       begin lo_v = 21'h800;   hi_v = 21'hFFFF;   end
      default: begin lo_v = 21'h10000; hi_v = 21'h10FFFF; end
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 0)      v = lo_v;
    else if (pick == 1) v = hi_v;
    else                v = cp_t'($urandom_range(lo_v, hi_v));
    if (v >= 21'hD800 && v <= 21'hDFFF) v = v ^ 21'h2000;
    return v;
  endfunction

  task automatic push_break(input break_e kind);
    int unsigned r;
    case (kind)
      BRK_STRAY_CONT: utf8_bytes.push_back(8'(8'h80 + $urandom_range(0, 63)));
      BRK_BAD_BYTE: begin
        r = $urandom_range(0, 12);
        utf8_bytes.push_back(r < 2 ? 8'(8'hC0 + r) : 8'(8'hF5 + r - 2));
      end
      BRK_OVERLONG: begin
        if ($urandom_range(0, 1) == 0) begin
          utf8_bytes.push_back(8'hE0);
          utf8_bytes.push_back(8'(8'h80 + $urandom_range(0, 31)));
        end else begin
          utf8_bytes.push_back(8'hF0);
          utf8_bytes.push_back(8'(8'h80 + $urandom_range(0, 15)));
        end
      end
      BRK_SURROGATE: begin
        utf8_bytes.push_back(8'hED);
        utf8_bytes.push_back(8'(8'hA0 + $urandom_range(0, 31)));
        utf8_bytes.push_back(8'(8'h80 + $urandom_range(0, 63)));
      end
      BRK_ABOVE_MAX: begin
        utf8_bytes.push_back(8'hF4);
        utf8_bytes.push_back(8'(8'h90 + $urandom_range(0, 47)));
      end
      default: begin
        // lead byte cut short by an ASCII byte
        utf8_bytes.push_back(8'(8'hC2 + $urandom_range(0, 29)));
        utf8_bytes.push_back(8'($urandom_range(0, 127)));
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_count <= 0;
    end else if (cp_if.valid && cp_if.ready) begin
      rx_count <= rx_count + 1;
    end
  end

  // one long receiver hold-off so the decoder fills and stalls its input
  initial begin
    long_hold = 1'b0;
    wait (rst_ni === 1'b1);
    wait (rx_count >= HoldAfter);
    @(negedge clk_i);
    long_hold <= 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    long_hold <= 1'b0;
  end

  initial begin : rx_proc
    int stall;
    int loops;
    bit rx_steady;
    cp_if.ready = 1'b0;
    rx_steady   = 1'b0;
    loops       = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (loops % 64 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      loops++;
      stall = rx_steady ? 0 : $urandom_range(0, 6);
      if (stall != 0 || long_hold) begin
        cp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
        while (long_hold) @(negedge clk_i);
      end
      cp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!cp_if.valid);
      @(negedge clk_i);
    end
  end

  initial begin : tx_proc
    int gap;
    bit tx_steady;
    rst_ni          = 1'b0;
    byte_if.valid   = 1'b0;
    byte_if.in_byte = '0;
    tx_steady       = 1'b0;

    push_scalar(21'h0);
    push_scalar(21'h7F);
    push_scalar(21'h80);
    push_scalar(21'h7FF);
    push_scalar(21'h800);
    push_scalar(21'hD7FF);
    push_scalar(21'hE000);
    push_scalar(21'hFFFF);
    push_scalar(21'h10000);
    push_scalar(21'h10FFFF);
    while (utf8_bytes.size() < RandomBytes) push_scalar(random_scalar());
    push_break(break_e'($urandom_range(0, 5)));
    repeat (NoiseBytes) utf8_bytes.push_back(8'($urandom_range(0, 255)));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < utf8_bytes.size(); i++) begin
      if (i % 100 == 0) tx_steady = ($urandom_range(0, 2) == 0);
      gap = tx_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      byte_if.valid   <= 1'b1;
      byte_if.in_byte <= utf8_bytes[i];
      do @(posedge clk_i); while (!byte_if.ready);
      @(negedge clk_i);
    end
    byte_if.valid <= 1'b0;

    wait (pending == 0);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: utf8_dfa_decoder_core.f
hdl/udfa_pkg.sv
hdl/udfa_if.sv
hdl/udfa_front.sv
hdl/udfa_back.sv
hdl/utf8_dfa_decoder_core.sv
verif/udfa_checker.sv
verif/tb_top.sv
